// File: src/msr_pkg.sv
package msr_pkg;

	// Largest matrix side and the store depth that follows from it.
	localparam int MaxDim     = 8;
	localparam int StoreDepth = MaxDim * MaxDim;
	localparam int IdxW       = $clog2(MaxDim);
	localparam int AddrW      = $clog2(StoreDepth);
	localparam int DimW       = 4;
	localparam int CountW     = 7;
	localparam int DataW      = 32;
	localparam int OutDataW   = 40;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_ROWS = 2'd0,
		REG_COLS = 2'd1,
		REG_MODE = 2'd2
	} reg_idx_t;

	// Output order codes; the unused code behaves as row-wise.
	typedef enum logic [1:0] {
		MODE_ROW    = 2'd0,
		MODE_COL    = 2'd1,
		MODE_SPIRAL = 2'd2
	} order_mode_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_LOAD,
		ST_READ,
		ST_SEND
	} state_t;

	// Current leg of the spiral walk.
	typedef enum logic [1:0] {
		DIR_RIGHT,
		DIR_DOWN,
		DIR_LEFT,
		DIR_UP
	} dir_t;

	// Effective dimension: zero acts as one, anything above MaxDim saturates.
	function automatic logic [DimW-1:0] eff_dim(input logic [DimW-1:0] v);
		logic [DimW-1:0] res;
		if (v == '0) begin
			res = DimW'(1);
		end else if (v > DimW'(MaxDim)) begin
			res = DimW'(MaxDim);
		end else begin
			res = v;
		end
		return res;
	endfunction

endpackage

// File: src/matrix_spiral_reorder.sv
// Matrix reorder buffer.
// Elements arrive on the s_axis stream in row-major order, one word each.
// When rows*cols words have been taken, the input closes (s_axis_tready low)
// and every stored element leaves on the m_axis stream in the order set by
// the mode register: row-wise, column-wise or clockwise spiral from the
// outer ring inward. Each output word carries the value, its row and its
// column; tlast marks the final word of the matrix. The input then reopens
// for the next matrix.
// After the last input word, a read state registers the store read and a
// send state then offers the word; each later word repeats the read and
// send states. When the receiver stalls, the output word holds and the walk
// waits. The cfg channel writes rows (index 0), cols (index 1) and the mode
// (index 2); it is always ready. It is to be used only while the block is
// idle; the block itself does not enforce this. Writing rows or cols
// discards a partly loaded matrix.
// Reset sets rows and cols to 8, the mode to spiral and the load count to
// zero. The element store holds no reset value; every word read out has
// been written during the current load.
module matrix_spiral_reorder import msr_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	// Configuration write channel.
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [DimW-1:0]     cfg_data,
	// Input stream.
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [DataW-1:0]    s_axis_tdata,  // element[31:0]
	// Output stream.
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [OutDataW-1:0] m_axis_tdata,  // out_value[31:0], out_row[34:32],
	                                            // out_col[37:35], zero fill[39:38]
	output logic                m_axis_tlast   // out_last
);

	// Configuration registers.
	logic [DimW-1:0] rows_q;
	logic [DimW-1:0] cols_q;
	logic [1:0]      mode_q;

	// Control state.
	state_t            state_q, state_n;
	logic [CountW-1:0] load_count_q;
	logic [IdxW-1:0]   r_q, c_q, r_n, c_n;
	logic [IdxW-1:0]   top_q, bot_q, left_q, right_q;
	logic [IdxW-1:0]   top_n, bot_n, left_n, right_n;
	dir_t              dir_q, dir_n;
	logic [AddrW-1:0]  idx_q;

	// Element store and its registered read port.
	logic [DataW-1:0] mem [StoreDepth];
	logic [DataW-1:0] rd_data_q;

	logic [DimW-1:0]   nr_eff, nc_eff;
	logic [IdxW-1:0]   last_row, last_col;
	logic [CountW-1:0] total;
	logic [CountW-1:0] addr_full;
	logic [AddrW-1:0]  rd_addr;
	logic              s_fire, m_fire, cfg_fire, last_word, load_done;

	// Effective shape and derived values.
	assign nr_eff    = eff_dim(rows_q);
	assign nc_eff    = eff_dim(cols_q);
	assign last_row  = IdxW'(nr_eff - DimW'(1));
	assign last_col  = IdxW'(nc_eff - DimW'(1));
	assign total     = CountW'(nr_eff) * CountW'(nc_eff);
	assign addr_full = CountW'(r_q) * CountW'(nc_eff) + CountW'(c_q);
	assign rd_addr   = addr_full[AddrW-1:0];

	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid & cfg_ready;
	assign s_fire    = s_axis_tvalid & s_axis_tready;
	assign m_fire    = m_axis_tvalid & m_axis_tready;
	assign load_done = (load_count_q + CountW'(1)) >= total;
	assign last_word = ({1'b0, idx_q} == (total - CountW'(1)));

	assign m_axis_tdata = {2'b00, c_q, r_q, rd_data_q};
	assign m_axis_tlast = last_word;

	// Configuration writes; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= DimW'(MaxDim);
			cols_q <= DimW'(MaxDim);
			mode_q <= MODE_SPIRAL;
		end else if (cfg_fire) begin
			if (cfg_index == REG_ROWS) begin
				rows_q <= cfg_data;
			end
			if (cfg_index == REG_COLS) begin
				cols_q <= cfg_data;
			end
			if (cfg_index == REG_MODE) begin
				mode_q <= cfg_data[1:0];
			end
		end
	end

	// Store write on each accepted word, registered read ahead of each send.
	always_ff @(posedge clk) begin
		if (s_fire) begin
			mem[load_count_q[AddrW-1:0]] <= s_axis_tdata;
		end
		if (state_q == ST_READ) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// Next position of the walk for the selected order.
	always_comb begin
		r_n     = r_q;
		c_n     = c_q;
		top_n   = top_q;
		bot_n   = bot_q;
		left_n  = left_q;
		right_n = right_q;
		dir_n   = dir_q;
		unique case (mode_q)
			MODE_COL: begin
				if (r_q == last_row) begin
					r_n = '0;
					c_n = c_q + IdxW'(1);
				end else begin
					r_n = r_q + IdxW'(1);
				end
			end
			MODE_SPIRAL: begin
				// Turn at the end of each leg and pull in that edge.
				unique case (dir_q)
					DIR_RIGHT: begin
						if (c_q == right_q) begin
							top_n = top_q + IdxW'(1);
							r_n   = r_q + IdxW'(1);
							dir_n = DIR_DOWN;
						end else begin
							c_n = c_q + IdxW'(1);
						end
					end
					DIR_DOWN: begin
						if (r_q == bot_q) begin
							right_n = right_q - IdxW'(1);
							c_n     = c_q - IdxW'(1);
							dir_n   = DIR_LEFT;
						end else begin
							r_n = r_q + IdxW'(1);
						end
					end
					DIR_LEFT: begin
						if (c_q == left_q) begin
							bot_n = bot_q - IdxW'(1);
							r_n   = r_q - IdxW'(1);
							dir_n = DIR_UP;
						end else begin
							c_n = c_q - IdxW'(1);
						end
					end
					DIR_UP: begin
						if (r_q == top_q) begin
							left_n = left_q + IdxW'(1);
							c_n    = c_q + IdxW'(1);
							dir_n  = DIR_RIGHT;
						end else begin
							r_n = r_q - IdxW'(1);
						end
					end
					default: begin
						dir_n = DIR_RIGHT;
					end
				endcase
			end
			default: begin
				if (c_q == last_col) begin
					c_n = '0;
					r_n = r_q + IdxW'(1);
				end else begin
					c_n = c_q + IdxW'(1);
				end
			end
		endcase
	end

	// Sequencer next state and handshake outputs.
	always_comb begin
		state_n       = state_q;
		s_axis_tready = 1'b0;
		m_axis_tvalid = 1'b0;
		unique case (state_q)
			ST_LOAD: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid && load_done) begin
					state_n = ST_READ;
				end
			end
			ST_READ: begin
				state_n = ST_SEND;
			end
			ST_SEND: begin
				m_axis_tvalid = 1'b1;
				if (m_axis_tready) begin
					state_n = last_word ? ST_LOAD : ST_READ;
				end
			end
			default: begin
				state_n = ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_n;
		end
	end

	// Load count and walk registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_count_q <= '0;
			r_q          <= '0;
			c_q          <= '0;
			top_q        <= '0;
			bot_q        <= '0;
			left_q       <= '0;
			right_q      <= '0;
			dir_q        <= DIR_RIGHT;
			idx_q        <= '0;
		end else if (cfg_fire && (cfg_index == REG_ROWS || cfg_index == REG_COLS)) begin
			load_count_q <= '0;
		end else if (s_fire) begin
			if (load_done) begin
				// Matrix complete: start the walk at the top left corner.
				load_count_q <= '0;
				r_q          <= '0;
				c_q          <= '0;
				top_q        <= '0;
				bot_q        <= last_row;
				left_q       <= '0;
				right_q      <= last_col;
				dir_q        <= DIR_RIGHT;
				idx_q        <= '0;
			end else begin
				load_count_q <= load_count_q + CountW'(1);
			end
		end else if (m_fire) begin
			r_q     <= r_n;
			c_q     <= c_n;
			top_q   <= top_n;
			bot_q   <= bot_n;
			left_q  <= left_n;
			right_q <= right_n;
			dir_q   <= dir_n;
			idx_q   <= idx_q + AddrW'(1);
		end
	end

endmodule

// File: tb/sv/tb_top.sv
module tb_top;
	import msr_pkg::*;

	// Codes the package leaves without a name.
	localparam logic [1:0] RegUnused  = 2'd3;
	localparam logic [1:0] ModeUnused = 2'd3;

	// Cycles without any accepted word before the run is declared hung.
	localparam int StallLimit = 3000;
	// Quiet cycles after the last word of a matrix before touching config.
	localparam int SettleCycles = 8;

	// One word of a traversal as it should leave the block.
	typedef struct packed {
		logic [DataW-1:0] value;
		logic [IdxW-1:0]  row;
		logic [IdxW-1:0]  col;
		logic             last;
	} matrix_word_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [1:0]          cfg_index = '0;
	logic [DimW-1:0]     cfg_data = '0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [DataW-1:0]    s_axis_tdata = '0;
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [OutDataW-1:0] m_axis_tdata;
	logic                m_axis_tlast;

	// Shadow copy of the block's registers and store.
	logic [DimW-1:0]   shadow_rows = DimW'(8);
	logic [DimW-1:0]   shadow_cols = DimW'(8);
	logic [1:0]        shadow_mode = MODE_SPIRAL;
	logic [CountW-1:0] shadow_count = '0;
	logic [DataW-1:0]  shadow_store [StoreDepth];

	// Traversal words predicted but not yet seen on the output.
	matrix_word_t traversal_queue [$];

	int mismatch_count = 0;
	int idle_pct = 0;
	int stall_pct = 0;
	int quiet_cycles = 0;

	matrix_spiral_reorder dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Dimension in use: zero counts as one, larger than MaxDim saturates.
	function automatic int clamp_dim(input logic [DimW-1:0] v);
		int d;
		d = int'(v);
		if (d < 1) begin
			d = 1;
		end else if (d > MaxDim) begin
			d = MaxDim;
		end
		return d;
	endfunction

	task automatic report_mismatch(input string what, input logic [DataW-1:0] got,
			input logic [DataW-1:0] want);
		mismatch_count++;
		$display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
	endtask

	// Queue the stored element (r,c) of a matrix that is nc columns wide.
	task automatic queue_word(input int r, input int c, input int nc);
		matrix_word_t w;
		w.value = shadow_store[(r * nc + c) % StoreDepth];
		w.row   = IdxW'(r);
		w.col   = IdxW'(c);
		w.last  = 1'b0;
		traversal_queue.push_back(w);
	endtask

	// Register write as the block sees it.
	task automatic apply_reg_write(input logic [1:0] idx, input logic [DimW-1:0] val);
		case (idx)
			REG_ROWS: begin
				shadow_rows  = val;
				shadow_count = '0;
			end
			REG_COLS: begin
				shadow_cols  = val;
				shadow_count = '0;
			end
			REG_MODE: begin
				shadow_mode = val[1:0];
			end
			default: begin
			end
		endcase
	endtask

	// Store one element; when the matrix is complete, queue its whole traversal.
	task automatic load_and_walk(input logic [DataW-1:0] element);
		int nr, nc, r, c, top, bot, lo, hi;
		nr = clamp_dim(shadow_rows);
		nc = clamp_dim(shadow_cols);
		shadow_store[shadow_count % StoreDepth] = element;
		shadow_count = shadow_count + CountW'(1);
		if (int'(shadow_count) < nr * nc) begin
			return;
		end
		shadow_count = '0;
		if (shadow_mode == MODE_COL) begin
			for (c = 0; c < nc; c++) begin
				for (r = 0; r < nr; r++) begin
					queue_word(r, c, nc);
				end
			end
		end else if (shadow_mode == MODE_SPIRAL) begin
			// Peel rings: top row, right column, bottom row, left column.
			top = 0;
			bot = nr - 1;
			lo  = 0;
			hi  = nc - 1;
			while (top <= bot && lo <= hi) begin
				for (c = lo; c <= hi; c++) begin
					queue_word(top, c, nc);
				end
				top++;
				for (r = top; r <= bot; r++) begin
					queue_word(r, hi, nc);
				end
				hi--;
				if (top <= bot) begin
					for (c = hi; c >= lo; c--) begin
						queue_word(bot, c, nc);
					end
				end
				bot--;
				if (lo <= hi) begin
					for (r = bot; r >= top; r--) begin
						queue_word(r, lo, nc);
					end
				end
				lo++;
			end
		end else begin
			// Row-wise, which the unused mode code falls back to as well.
			for (r = 0; r < nr; r++) begin
				for (c = 0; c < nc; c++) begin
					queue_word(r, c, nc);
				end
			end
		end
		traversal_queue[traversal_queue.size() - 1].last = 1'b1;
	endtask

	// Follow every accepted word: config writes and elements feed the shadow
	// model, output words are checked against the oldest prediction.
	always @(posedge clk) begin : scoreboard
		matrix_word_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				apply_reg_write(cfg_index, cfg_data);
			end
			if (s_axis_tvalid && s_axis_tready) begin
				load_and_walk(s_axis_tdata);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (traversal_queue.size() == 0) begin
					report_mismatch("output word with nothing pending",
						m_axis_tdata[31:0], '0);
				end else begin
					want = traversal_queue.pop_front();
					if (m_axis_tdata[31:0] !== want.value) begin
						report_mismatch("out_value", m_axis_tdata[31:0], want.value);
					end
					if (m_axis_tdata[34:32] !== want.row) begin
						report_mismatch("out_row", DataW'(m_axis_tdata[34:32]),
							DataW'(want.row));
					end
					if (m_axis_tdata[37:35] !== want.col) begin
						report_mismatch("out_col", DataW'(m_axis_tdata[37:35]),
							DataW'(want.col));
					end
					if (m_axis_tlast !== want.last) begin
						report_mismatch("out_last", DataW'(m_axis_tlast),
							DataW'(want.last));
					end
				end
			end
		end
	end

	// Receiver side: random back-pressure at the current stall rate.
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99, 0) >= stall_pct);
	end

	// Hang detection: count cycles in which no word moves on any channel.
	always @(posedge clk) begin
		if ((cfg_valid && cfg_ready) || (s_axis_tvalid && s_axis_tready) ||
				(m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= StallLimit) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic set_idling(input int sender, input int receiver);
		idle_pct  = sender;
		stall_pct = receiver;
	endtask

	// Offer one element, with a random gap first, and wait until it is taken.
	task automatic send_element(input logic [DataW-1:0] element);
		while ($urandom_range(99, 0) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= element;
		do begin
			@(posedge clk);
		end while (!s_axis_tready);
	endtask

	// Close a burst of elements so no stale word is offered afterwards.
	task automatic end_burst();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [DimW-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Let the current traversal drain before the block is reconfigured.
	task automatic settle();
		while (traversal_queue.size() != 0) begin
			@(posedge clk);
		end
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic reconfigure(input logic [DimW-1:0] r, input logic [DimW-1:0] c,
			input logic [1:0] m);
		settle();
		write_reg(REG_ROWS, r);
		write_reg(REG_COLS, c);
		write_reg(REG_MODE, DimW'(m));
		if ($urandom_range(7, 0) == 0) begin
			write_reg(RegUnused, DimW'($urandom_range(15, 0)));
		end
	endtask

	// An 8 by 8 spiral straight out of reset, with no register written.
	task automatic test_reset_shape();
		repeat (MaxDim * MaxDim) send_element($urandom);
		end_burst();
	endtask

	// Zero dimensions act as one; a 2 by 2 row-wise pass carries the value extremes.
	task automatic test_small_extremes();
		reconfigure('0, '0, MODE_SPIRAL);
		send_element(32'h8000_0000);
		end_burst();
		reconfigure(DimW'(2), DimW'(2), MODE_ROW);
		send_element(32'h7fff_ffff);
		send_element(32'hffff_ffff);
		send_element(32'h0000_0000);
		send_element(32'h8000_0000);
		end_burst();
	endtask

	// The unused mode code must fall back to row-wise order.
	task automatic test_unused_mode();
		reconfigure(DimW'(2), DimW'(3), ModeUnused);
		repeat (6) send_element($urandom);
		end_burst();
	endtask

	// A saturated row count gives an 8 by 1 column walked as a spiral.
	task automatic test_tall_spiral();
		reconfigure(DimW'(15), DimW'(1), MODE_SPIRAL);
		repeat (MaxDim) send_element($urandom);
		end_burst();
	endtask

	// A shape write discards a partial matrix; a mode or unknown write does not.
	task automatic test_shape_change_midload();
		reconfigure(DimW'(2), DimW'(2), MODE_SPIRAL);
		repeat (3) send_element($urandom);
		end_burst();
		write_reg(REG_COLS, DimW'(2));
		write_reg(RegUnused, DimW'(10));
		repeat (2) send_element($urandom);
		end_burst();
		write_reg(REG_MODE, DimW'(MODE_COL));
		repeat (2) send_element($urandom);
		end_burst();
	endtask

	// Random shapes, modes and contents; now and then a matrix is cut short
	// and thrown away by the next shape write.
	task automatic test_random_matrices(input int budget);
		int sent, total, count;
		logic [DimW-1:0] rv, cv;
		logic [1:0] mv;
		sent = 0;
		while (sent < budget) begin
			if ($urandom_range(99, 0) < 85) begin
				rv = DimW'($urandom_range(4, 1));
				cv = DimW'($urandom_range(4, 1));
			end else begin
				rv = DimW'($urandom_range(15, 0));
				cv = DimW'($urandom_range(15, 0));
			end
			mv = 2'($urandom_range(3, 0));
			reconfigure(rv, cv, mv);
			total = clamp_dim(rv) * clamp_dim(cv);
			count = total;
			if (total > 1 && $urandom_range(5, 0) == 0) begin
				count = $urandom_range(total - 1, 1);
			end
			repeat (count) send_element($urandom);
			end_burst();
			sent += count;
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_idling(0, 0);
		test_reset_shape();
		test_small_extremes();
		test_unused_mode();
		test_tall_spiral();
		test_shape_change_midload();

		set_idling(0, 0);
		test_random_matrices(8);
		set_idling(79, 0);
		test_random_matrices(8);
		set_idling(0, 79);
		test_random_matrices(8);
		set_idling(27, 27);
		test_random_matrices(8);

		// Drain, then watch a little longer for stray output words.
		while (traversal_queue.size() != 0) begin
			@(posedge clk);
		end
		repeat (20) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// File: filelist.f
src/msr_pkg.sv
src/matrix_spiral_reorder.sv
tb/sv/tb_top.sv
